FILE: hw/rtl/btmx_pkg.sv
// Shared types, codes and default sizes for the binary trie max-xor block.
package btmx_pkg;

   // Key width is fixed by the request field.
   localparam int KEY_BITS = 31;

   // Default pool size and item limit for the top level.
   localparam int NODE_COUNT_DEF = 4096;
   localparam int MAX_ITEMS_DEF  = 1024;

   // Operation codes.
   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_REMOVE = 2'd1;
   localparam logic [1:0] FUNC_QUERY  = 2'd2;

   // Status codes.
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_FULL   = 2'd1;
   localparam logic [1:0] STATUS_ABSENT = 2'd2;
   localparam logic [1:0] STATUS_EMPTY  = 2'd3;

   typedef struct packed {
      logic [1:0]          func;
      logic [KEY_BITS-1:0] key;
   } req_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] xor_result;
      logic [1:0]          status;
   } rsp_type;

endpackage

FILE: hw/rtl/bitwise_trie_max_xor.sv
// Binary trie over 31-bit keys with insert, remove and max-xor query.
//
// Usage: a request beat carries an operation and a key on req_data; it is taken
// at a rising edge with req_valid high and req_stall low. Every request gives
// exactly one response beat on rsp_data (xor result and status), taken at an
// edge with rsp_valid high and rsp_stall low.
// The block works on one request at a time and holds req_stall high until
// it has finished. An insert or remove walks the trie twice, once to check
// and once to update, one trie level per cycle.
// An insert's check walk stops at the first missing node, and a remove
// that finds its key absent skips the update walk. A query walks once,
// and its walk ends early where its path ends. A request rejected at the
// root (full, empty, absent) or with an unused opcode goes straight to the
// response state. The pace of the walks is set by the single node memory,
// which gives one node per cycle to the walk.
// Reset empties the set at once: the root lives in flip-flops and the pool
// fill count returns to one, so no clearing pass is needed.
// A stalled response waits in the output register; the next request is still
// accepted meanwhile, and its response waits until that register is free.
module bitwise_trie_max_xor #(
   parameter int NODE_COUNT = btmx_pkg::NODE_COUNT_DEF,
   parameter int MAX_ITEMS  = btmx_pkg::MAX_ITEMS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  btmx_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output btmx_pkg::rsp_type rsp_data
);
   import btmx_pkg::*;

   localparam int NODE_W = $clog2(NODE_COUNT);
   localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
   localparam int FREE_W = NODE_W + 1;
   localparam int LVL_W  = $clog2(KEY_BITS);
   localparam int WORD_W = 2 * NODE_W + 2 * CNT_W;
   localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(KEY_BITS - 1);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_UPDATE = 3'd2;
   localparam logic [2:0] ST_QUERY  = 3'd3;
   localparam logic [2:0] ST_RESP   = 3'd4;

   // Each node word holds both child links and the key counts of both children.
   logic [WORD_W-1:0] node_mem [NODE_COUNT];

   logic [2:0]          state_ff, state_in;
   logic [1:0]          func_ff, func_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [NODE_W-1:0]   cur_ff, cur_in;
   logic [LVL_W-1:0]    level_ff, level_in;
   logic                fresh_ff, fresh_in;
   logic [KEY_BITS-1:0] acc_ff, acc_in;
   logic [1:0]          status_ff, status_in;
   logic [FREE_W-1:0]   next_free_ff, next_free_in;
   logic [CNT_W-1:0]    root_count_ff, root_count_in;
   logic [NODE_W-1:0]   root_link0_ff, root_link0_in;
   logic [NODE_W-1:0]   root_link1_ff, root_link1_in;
   logic [CNT_W-1:0]    root_cnt0_ff, root_cnt0_in;
   logic [CNT_W-1:0]    root_cnt1_ff, root_cnt1_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic [WORD_W-1:0]   rd_data_ff;

   logic                wr_en;
   logic [NODE_W-1:0]   wr_addr;
   logic [WORD_W-1:0]   wr_data;

   logic [NODE_W-1:0]   w_link0, w_link1, link_b, link_o, next_node;
   logic [CNT_W-1:0]    w_cnt0, w_cnt1, cnt_b, cnt_o;
   logic [NODE_W-1:0]   n_link0, n_link1;
   logic [CNT_W-1:0]    n_cnt0, n_cnt1;
   logic                bit_sel, last_level;
   logic [FREE_W:0]     need_nodes;

   // Current node word: root from flip-flops, a freshly allocated node as empty.
   always_comb begin
      if (cur_ff == '0) begin
         w_link0 = root_link0_ff;
         w_link1 = root_link1_ff;
         w_cnt0  = root_cnt0_ff;
         w_cnt1  = root_cnt1_ff;
      end else if (fresh_ff) begin
         w_link0 = '0;
         w_link1 = '0;
         w_cnt0  = '0;
         w_cnt1  = '0;
      end else begin
         {w_link1, w_link0, w_cnt1, w_cnt0} = rd_data_ff;
      end
   end

   // Child on the key's side and on the opposite side.
   assign bit_sel    = key_ff[level_ff];
   assign last_level = (level_ff == '0);
   assign link_b     = bit_sel ? w_link1 : w_link0;
   assign cnt_b      = bit_sel ? w_cnt1 : w_cnt0;
   assign link_o     = bit_sel ? w_link0 : w_link1;
   assign cnt_o      = bit_sel ? w_cnt0 : w_cnt1;

   // Pool use if the path is missing from this level down.
   assign need_nodes = {1'b0, next_free_ff} + (FREE_W + 1)'(level_ff) + (FREE_W + 1)'(1);

   // Sequencer and datapath.
   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      key_in        = key_ff;
      cur_in        = cur_ff;
      level_in      = level_ff;
      fresh_in      = fresh_ff;
      acc_in        = acc_ff;
      status_in     = status_ff;
      next_free_in  = next_free_ff;
      root_count_in = root_count_ff;
      root_link0_in = root_link0_ff;
      root_link1_in = root_link1_ff;
      root_cnt0_in  = root_cnt0_ff;
      root_cnt1_in  = root_cnt1_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      wr_en         = 1'b0;
      wr_addr       = cur_ff;
      n_link0       = w_link0;
      n_link1       = w_link1;
      n_cnt0        = w_cnt0;
      n_cnt1        = w_cnt1;
      next_node     = link_b;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in   = req_data.func;
               key_in    = req_data.key;
               cur_in    = '0;
               level_in  = LVL_TOP;
               fresh_in  = 1'b0;
               acc_in    = '0;
               status_in = STATUS_OK;
               unique case (req_data.func)
                  FUNC_INSERT: begin
                     if (root_count_ff >= CNT_W'(MAX_ITEMS)) begin
                        status_in = STATUS_FULL;
                        state_in  = ST_RESP;
                     end else begin
                        state_in = ST_CHECK;
                     end
                  end
                  FUNC_REMOVE: begin
                     if (root_count_ff == '0) begin
                        status_in = STATUS_ABSENT;
                        state_in  = ST_RESP;
                     end else begin
                        state_in = ST_CHECK;
                     end
                  end
                  FUNC_QUERY: begin
                     if (root_count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                        state_in  = ST_RESP;
                     end else begin
                        state_in = ST_QUERY;
                     end
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         // Read-only walk that decides whether the update may go ahead.
         ST_CHECK: begin
            if (func_ff == FUNC_INSERT) begin
               if (link_b == '0) begin
                  if (need_nodes > (FREE_W + 1)'(NODE_COUNT)) begin
                     status_in = STATUS_FULL;
                     state_in  = ST_RESP;
                  end else begin
                     state_in = ST_UPDATE;
                     cur_in   = '0;
                     level_in = LVL_TOP;
                  end
               end else if (last_level) begin
                  state_in = ST_UPDATE;
                  cur_in   = '0;
                  level_in = LVL_TOP;
               end else begin
                  cur_in   = link_b;
                  level_in = level_ff - LVL_W'(1);
               end
            end else begin
               if (link_b == '0 || cnt_b == '0) begin
                  status_in = STATUS_ABSENT;
                  state_in  = ST_RESP;
               end else if (last_level) begin
                  state_in = ST_UPDATE;
                  cur_in   = '0;
                  level_in = LVL_TOP;
               end else begin
                  cur_in   = link_b;
                  level_in = level_ff - LVL_W'(1);
               end
            end
         end

         // Writing walk: one node word rewritten per level.
         ST_UPDATE: begin
            if (func_ff == FUNC_INSERT) begin
               if (link_b == '0) begin
                  next_node    = next_free_ff[NODE_W-1:0];
                  next_free_in = next_free_ff + FREE_W'(1);
                  fresh_in     = 1'b1;
               end
               if (bit_sel) begin
                  n_link1 = next_node;
                  n_cnt1  = w_cnt1 + CNT_W'(1);
               end else begin
                  n_link0 = next_node;
                  n_cnt0  = w_cnt0 + CNT_W'(1);
               end
               if (cur_ff == '0) begin
                  root_count_in = root_count_ff + CNT_W'(1);
               end
            end else begin
               if (bit_sel) begin
                  n_cnt1 = w_cnt1 - CNT_W'(1);
               end else begin
                  n_cnt0 = w_cnt0 - CNT_W'(1);
               end
               if (cur_ff == '0) begin
                  root_count_in = root_count_ff - CNT_W'(1);
               end
            end
            if (cur_ff == '0) begin
               root_link0_in = n_link0;
               root_link1_in = n_link1;
               root_cnt0_in  = n_cnt0;
               root_cnt1_in  = n_cnt1;
            end else begin
               wr_en = 1'b1;
            end
            if (last_level) begin
               state_in = ST_RESP;
            end else begin
               cur_in   = next_node;
               level_in = level_ff - LVL_W'(1);
            end
         end

         // Greedy walk towards the opposite bit where a key lives there.
         ST_QUERY: begin
            if (link_o != '0 && cnt_o != '0) begin
               acc_in[level_ff] = 1'b1;
               next_node        = link_o;
            end
            if ((link_o == '0 || cnt_o == '0) && link_b == '0) begin
               state_in = ST_RESP;
            end else if (last_level) begin
               state_in = ST_RESP;
            end else begin
               cur_in   = next_node;
               level_in = level_ff - LVL_W'(1);
            end
         end

         // Hand the result to the output register once it is free.
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.xor_result = acc_ff;
               rsp_data_in.status     = status_ff;
               state_in               = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign wr_data = {n_link1, n_link0, n_cnt1, n_cnt0};

   // Control state and root node.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         next_free_ff  <= FREE_W'(1);
         root_count_ff <= '0;
         root_link0_ff <= '0;
         root_link1_ff <= '0;
         root_cnt0_ff  <= '0;
         root_cnt1_ff  <= '0;
         fresh_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         next_free_ff  <= next_free_in;
         root_count_ff <= root_count_in;
         root_link0_ff <= root_link0_in;
         root_link1_ff <= root_link1_in;
         root_cnt0_ff  <= root_cnt0_in;
         root_cnt1_ff  <= root_cnt1_in;
         fresh_ff      <= fresh_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      key_ff      <= key_in;
      cur_ff      <= cur_in;
      level_ff    <= level_in;
      acc_ff      <= acc_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Node memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= node_mem[cur_in];
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The pool fill count never runs past the pool.
   assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= FREE_W'(NODE_COUNT))
      else $error("Node pool fill count beyond pool size.");

   // The number of stored keys never exceeds the item limit.
   assert property (@(posedge clock) disable iff (reset)
      root_count_ff <= CNT_W'(MAX_ITEMS))
      else $error("Stored key count beyond item limit.");

   // A new response beat only follows the response state.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !($past(rsp_valid_ff) && $past(rsp_stall)))
      |-> $past(state_ff) == ST_RESP)
      else $error("Response beat without a finished request.");

   // Update walks touch allocated nodes only.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> ({1'b0, cur_ff} < next_free_ff))
      else $error("Update walk reached an unallocated node.");

   // Queries and checks never treat a node as freshly allocated.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QUERY || state_ff == ST_CHECK) |-> !fresh_ff)
      else $error("Fresh node flag set outside an insert update.");

endmodule

FILE: dv/bitwise_trie_max_xor_tb.sv
// Self-checking testbench for the binary trie max-xor block.
`timescale 1ns / 1ps

module bitwise_trie_max_xor_tb;
   import btmx_pkg::*;

   localparam int NODE_COUNT = NODE_COUNT_DEF;
   localparam int MAX_ITEMS  = MAX_ITEMS_DEF;
   // Opcode 3 has no meaning; the block must answer it with a plain OK.
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam logic [KEY_BITS-1:0] KEY_MAX = '1;

   // Directed stimulus row; want_* is only used where fixed is set.
   typedef struct {
      logic [1:0]          func;
      logic [KEY_BITS-1:0] key;
      bit                  fixed;
      logic [KEY_BITS-1:0] want_xor;
      logic [1:0]          want_status;
   } directed_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // Shadow trie: node links, counts below each node and the pool fill mark.
   logic [11:0] trie_link  [2*NODE_COUNT];
   logic [10:0] trie_count [NODE_COUNT];
   logic [12:0] trie_next_free;

   rsp_type             expected_rsp [$];
   logic [KEY_BITS-1:0] stored_keys  [$];
   logic [KEY_BITS-1:0] hot_keys     [12];

   int mismatch_count = 0;
   int rsp_seen       = 0;
   int no_gap_run     = 0;
   int pool_full_hits = 0;
   int set_full_hits  = 0;
   int absent_hits    = 0;
   int empty_hits     = 0;
   int op_count [4]   = '{0, 0, 0, 0};

   bitwise_trie_max_xor u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Overall time limit, well beyond the slowest legal run.
   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %h, want %h (response %0d)", what, got, want,
               rsp_seen);
      mismatch_count++;
   endtask

   function automatic int child_of(input int node, input logic b);
      return int'(trie_link[node*2 + int'(b)]);
   endfunction

   function automatic req_type make_req(input logic [1:0] func,
                                        input logic [KEY_BITS-1:0] key);
      req_type r;
      r.func = func;
      r.key  = key;
      return r;
   endfunction

   function automatic logic [KEY_BITS-1:0] pick_stored();
      logic [KEY_BITS-1:0] k;
      if (stored_keys.size() == 0) begin
         k = KEY_BITS'($urandom());
      end else begin
         k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      end
      return k;
   endfunction

   // Applies one operation to the shadow trie and returns the response it gives.
   function automatic rsp_type predict_trie(input req_type r);
      rsp_type             o;
      int                  node;
      int                  nx;
      int                  lvl;
      int                  missing;
      bit                  ok;
      logic                b;
      logic [KEY_BITS-1:0] acc;
      o = '0;
      o.status = STATUS_OK;
      case (r.func)
         FUNC_INSERT: begin
            if (int'(trie_count[0]) >= MAX_ITEMS) begin
               o.status = STATUS_FULL;
               set_full_hits++;
            end else begin
               // First pass: how many levels lack a node on this key's path.
               node = 0;
               missing = 0;
               for (lvl = KEY_BITS - 1; lvl >= 0 && missing == 0; lvl--) begin
                  nx = child_of(node, r.key[lvl]);
                  if (nx == 0) missing = lvl + 1;
                  else node = nx;
               end
               if (int'(trie_next_free) + missing > NODE_COUNT) begin
                  o.status = STATUS_FULL;
                  pool_full_hits++;
               end else begin
                  node = 0;
                  trie_count[0]++;
                  for (lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
                     b = r.key[lvl];
                     nx = child_of(node, b);
                     if (nx == 0) begin
                        nx = int'(trie_next_free);
                        trie_link[node*2 + int'(b)] = nx[11:0];
                        trie_next_free++;
                     end
                     node = nx;
                     trie_count[node]++;
                  end
               end
            end
         end
         FUNC_REMOVE: begin
            ok = (trie_count[0] != 0);
            node = 0;
            for (lvl = KEY_BITS - 1; lvl >= 0 && ok; lvl--) begin
               nx = child_of(node, r.key[lvl]);
               if (nx == 0 || trie_count[nx] == 0) ok = 1'b0;
               else node = nx;
            end
            if (!ok) begin
               o.status = STATUS_ABSENT;
               absent_hits++;
            end else begin
               node = 0;
               trie_count[0]--;
               for (lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
                  node = child_of(node, r.key[lvl]);
                  trie_count[node]--;
               end
            end
         end
         FUNC_QUERY: begin
            if (trie_count[0] == 0) begin
               o.status = STATUS_EMPTY;
               empty_hits++;
            end else begin
               // Greedy walk: take the opposite branch whenever it holds a key.
               node = 0;
               acc = '0;
               ok = 1'b1;
               for (lvl = KEY_BITS - 1; lvl >= 0 && ok; lvl--) begin
                  b = r.key[lvl];
                  nx = child_of(node, ~b);
                  if (nx != 0 && trie_count[nx] > 0) begin
                     acc[lvl] = 1'b1;
                     node = nx;
                  end else begin
                     node = child_of(node, b);
                     if (node == 0) ok = 1'b0;
                  end
               end
               o.xor_result = acc;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   // Offers one request beat, predicts its response once taken, then idles a while.
   task automatic send_request(input req_type r, input bit fixed, input rsp_type want);
      rsp_type predicted;
      int      gap;
      int      roll;
      int      j;
      bit      found;
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_trie(r);
      expected_rsp.push_back(fixed ? want : predicted);
      op_count[r.func]++;
      // Keep the list of stored keys in step for well-formed removes.
      if (predicted.status == STATUS_OK && r.func == FUNC_INSERT) begin
         stored_keys.push_back(r.key);
      end else if (predicted.status == STATUS_OK && r.func == FUNC_REMOVE) begin
         found = 1'b0;
         for (j = 0; j < stored_keys.size() && !found; j++) begin
            if (stored_keys[j] == r.key) begin
               stored_keys.delete(j);
               found = 1'b1;
            end
         end
      end
      // Gaps are mostly short, a few long, with occasional runs of none.
      if ($urandom_range(0, 59) == 0) no_gap_run = $urandom_range(10, 40);
      roll = $urandom_range(0, 99);
      if (no_gap_run > 0) begin
         no_gap_run--;
         gap = 0;
      end else if (roll < 55) gap = 0;
      else if (roll < 90) gap = $urandom_range(1, 3);
      else if (roll < 97) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 80);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Response side: random stalls, plus two long hold-offs that back the block up.
   initial begin : rsp_stall_gen
      int  stall_len;
      int  roll;
      bit  held_first;
      bit  held_second;
      held_first  = 1'b0;
      held_second = 1'b0;
      rsp_stall = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         roll = $urandom_range(0, 99);
         if (!held_first && rsp_seen >= 120) begin
            held_first = 1'b1;
            stall_len = 400;
         end else if (!held_second && rsp_seen >= 700) begin
            held_second = 1'b1;
            stall_len = 400;
         end else if (roll < 50) stall_len = 0;
         else if (roll < 90) stall_len = $urandom_range(1, 3);
         else if (roll < 98) stall_len = $urandom_range(4, 15);
         else stall_len = $urandom_range(30, 100);
         if (stall_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_len) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
      end
   end

   // Compare every response beat taken against the oldest expectation.
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected response", 32'(rsp_data), 32'h0);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.xor_result !== want.xor_result)
               report_mismatch("xor_result", 32'(rsp_data.xor_result),
                               32'(want.xor_result));
            if (rsp_data.status !== want.status)
               report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
         end
         rsp_seen++;
      end
   end

   // Main stimulus: reset, directed table, then random phases.
   initial begin : stimulus
      directed_row_type    directed [$];
      rsp_type             want;
      logic [KEY_BITS-1:0] k;
      int                  i;
      int                  roll;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      foreach (trie_link[n]) trie_link[n] = '0;
      foreach (trie_count[n]) trie_count[n] = '0;
      trie_next_free = 13'd1;
      hot_keys[0] = '0;
      hot_keys[1] = KEY_MAX;
      for (i = 2; i < 12; i++) hot_keys[i] = KEY_BITS'($urandom());

      // Directed rows: extremes, every opcode and each corner case.
      directed.push_back('{FUNC_QUERY,  31'h0,        1'b1, 31'h0,   STATUS_EMPTY});
      directed.push_back('{FUNC_REMOVE, KEY_MAX,      1'b1, 31'h0,   STATUS_ABSENT});
      directed.push_back('{FUNC_UNUSED, KEY_MAX,      1'b1, 31'h0,   STATUS_OK});
      directed.push_back('{FUNC_INSERT, 31'h0,        1'b1, 31'h0,   STATUS_OK});
      directed.push_back('{FUNC_QUERY,  KEY_MAX,      1'b1, KEY_MAX, STATUS_OK});
      directed.push_back('{FUNC_QUERY,  31'h0,        1'b1, 31'h0,   STATUS_OK});
      directed.push_back('{FUNC_INSERT, KEY_MAX,      1'b1, 31'h0,   STATUS_OK});
      directed.push_back('{FUNC_QUERY,  31'h0,        1'b1, KEY_MAX, STATUS_OK});
      directed.push_back('{FUNC_QUERY,  31'h2AAAAAAA, 1'b0, 31'h0,   STATUS_OK});
      directed.push_back('{FUNC_REMOVE, 31'h12345678, 1'b1, 31'h0,   STATUS_ABSENT});
      directed.push_back('{FUNC_INSERT, 31'h55555555, 1'b1, 31'h0,   STATUS_OK});
      directed.push_back('{FUNC_QUERY,  31'h55555555, 1'b0, 31'h0,   STATUS_OK});
      directed.push_back('{FUNC_QUERY,  31'h40000000, 1'b0, 31'h0,   STATUS_OK});
      directed.push_back('{FUNC_REMOVE, 31'h0,        1'b1, 31'h0,   STATUS_OK});
      directed.push_back('{FUNC_REMOVE, 31'h0,        1'b1, 31'h0,   STATUS_ABSENT});
      directed.push_back('{FUNC_QUERY,  KEY_MAX,      1'b0, 31'h0,   STATUS_OK});
      directed.push_back('{FUNC_INSERT, 31'h55555555, 1'b1, 31'h0,   STATUS_OK});
      directed.push_back('{FUNC_REMOVE, 31'h55555555, 1'b1, 31'h0,   STATUS_OK});
      directed.push_back('{FUNC_QUERY,  31'h2AAAAAAA, 1'b0, 31'h0,   STATUS_OK});
      directed.push_back('{FUNC_UNUSED, 31'h0,        1'b1, 31'h0,   STATUS_OK});
      directed.push_back('{FUNC_REMOVE, KEY_MAX,      1'b1, 31'h0,   STATUS_OK});
      directed.push_back('{FUNC_REMOVE, 31'h55555555, 1'b1, 31'h0,   STATUS_OK});
      directed.push_back('{FUNC_QUERY,  31'h1,        1'b1, 31'h0,   STATUS_EMPTY});
      directed.push_back('{FUNC_REMOVE, 31'h55555555, 1'b1, 31'h0,   STATUS_ABSENT});
      directed.push_back('{FUNC_INSERT, 31'h1,        1'b1, 31'h0,   STATUS_OK});

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[n]) begin
         want.xor_result = directed[n].want_xor;
         want.status     = directed[n].want_status;
         send_request(make_req(directed[n].func, directed[n].key), directed[n].fixed,
                      want);
      end
      want = '0;

      // Mixed traffic over a small set of hot keys, so paths are shared and revisited.
      for (i = 0; i < 100; i++) begin
         roll = $urandom_range(0, 99);
         if ($urandom_range(0, 9) == 0) k = KEY_BITS'($urandom());
         else k = hot_keys[$urandom_range(0, 11)];
         if (roll < 50) send_request(make_req(FUNC_INSERT, k), 1'b0, want);
         else if (roll < 62) send_request(make_req(FUNC_REMOVE, pick_stored()), 1'b0, want);
         else if (roll < 70) send_request(make_req(FUNC_REMOVE, k), 1'b0, want);
         else if (roll < 80) send_request(make_req(FUNC_QUERY, ~k), 1'b0, want);
         else if (roll < 95)
            send_request(make_req(FUNC_QUERY, KEY_BITS'($urandom())), 1'b0, want);
         else send_request(make_req(FUNC_UNUSED, KEY_BITS'($urandom())), 1'b0, want);
      end

      // Fresh random keys until the node pool runs out several times.
      for (i = 0; i < 400 && pool_full_hits < 6; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 75)
            send_request(make_req(FUNC_INSERT, KEY_BITS'($urandom())), 1'b0, want);
         else if (roll < 90)
            send_request(make_req(FUNC_QUERY, KEY_BITS'($urandom())), 1'b0, want);
         else send_request(make_req(FUNC_REMOVE, pick_stored()), 1'b0, want);
      end

      // Repeat stored keys, which need no new nodes, until the set limit is hit.
      for (i = 0; i < 2000 && set_full_hits < 4; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 93) send_request(make_req(FUNC_INSERT, pick_stored()), 1'b0, want);
         else if (roll < 98)
            send_request(make_req(FUNC_QUERY, KEY_BITS'($urandom())), 1'b0, want);
         else send_request(make_req(FUNC_INSERT, KEY_BITS'($urandom())), 1'b0, want);
      end

      // Drain part of the set again, with inserts that now fit once more.
      for (i = 0; i < 40; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 45) send_request(make_req(FUNC_REMOVE, pick_stored()), 1'b0, want);
         else if (roll < 60)
            send_request(make_req(FUNC_REMOVE, KEY_BITS'($urandom())), 1'b0, want);
         else if (roll < 70) send_request(make_req(FUNC_INSERT, pick_stored()), 1'b0, want);
         else if (roll < 95)
            send_request(make_req(FUNC_QUERY, KEY_BITS'($urandom())), 1'b0, want);
         else send_request(make_req(FUNC_UNUSED, KEY_BITS'($urandom())), 1'b0, want);
      end

      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);

      $display("Covered %0d inserts, %0d removes, %0d queries and %0d unused opcodes;",
               op_count[FUNC_INSERT], op_count[FUNC_REMOVE], op_count[FUNC_QUERY],
               op_count[FUNC_UNUSED]);
      $display("%0d beats checked; pool exhausted %0d times, set full %0d, absent %0d, empty %0d.",
               rsp_seen, pool_full_hits, set_full_hits, absent_hits, empty_hits);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
